// ===== rtl/awpd_pkg.sv =====
`default_nettype none

package awpd_pkg;

  // Default sizing of the top level
  localparam int MAX_WINDOW_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 8;
  localparam int COUNT_BITS_DEF  = 16;

  // Fixed register widths
  localparam int THR_BITS      = 8;
  localparam int WID_BITS      = 8;
  localparam int HOLD_BITS     = 16;
  localparam int LEN_CFG_BITS  = 5;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [LEN_CFG_BITS-1:0] LEN_RESET  = LEN_CFG_BITS'(1);
  localparam logic                    MODE_RESET = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD    = 3'd0,
    CFG_WINDOW_WIDTH = 3'd1,
    CFG_HOLD         = 3'd2,
    CFG_AVG_LENGTH   = 3'd3,
    CFG_AVG_MODE     = 3'd4
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== rtl/awpd_if.sv =====
`default_nettype none

interface awpd_in_if import awpd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] light_sample;

  modport source (output valid, output light_sample, input ready);
  modport sink   (input valid, input light_sample, output ready);
endinterface

interface awpd_out_if import awpd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   detected;
  logic [COUNT_BITS-1:0]  run_count;
  logic [SAMPLE_BITS-1:0] mean_value;
  logic                   window_full;

  modport source (output valid, output detected, output run_count, output mean_value,
                  output window_full, input ready);
  modport sink   (input valid, input detected, input run_count, input mean_value,
                  input window_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/averaged_window_persistence_detector.sv =====
`default_nettype none

// Averaged mode: each sample passes the read, divide and evaluate states; the divide state
//   runs the bit-serial restoring divider that forms the mean, one quotient bit a cycle.
// Averaged mode before the window fills skips the divide state. Raw mode goes straight to evaluate.
// The result sits in an output register, so the next sample is taken while it waits.
// Reset (async, active low) and any write to a known register clear the run counter and window;
// registers reset to threshold 0, width 0, hold 0, length 1, averaged mode.

module averaged_window_persistence_detector import awpd_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  awpd_in_if.sink                  sample_i,
  awpd_out_if.source               result_o
);

  localparam int POS_BITS     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_BITS     = POS_BITS + 1;
  localparam int SUM_BITS     = SAMPLE_BITS + POS_BITS;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
  localparam int CLAMP_BITS   = (LEN_BITS > LEN_CFG_BITS) ? LEN_BITS : LEN_CFG_BITS;
  localparam int CMP_BITS     = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 2;
  localparam int HCMP_BITS    = (COUNT_BITS > HOLD_BITS) ? COUNT_BITS : HOLD_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EVAL = 4'b1000
  } state_e;

  // Configuration registers
  logic [THR_BITS-1:0]     thr_q, thr_d;
  logic [WID_BITS-1:0]     wid_q, wid_d;
  logic [HOLD_BITS-1:0]    hold_q, hold_d;
  logic [LEN_CFG_BITS-1:0] len_q, len_d;
  logic                    mode_q, mode_d;

  // Control state
  state_e                  state_q, state_d;
  logic [POS_BITS-1:0]     pos_q, pos_d;
  logic [LEN_BITS-1:0]     fill_q, fill_d;
  logic [SUM_BITS-1:0]     sum_q, sum_d;
  logic [COUNT_BITS-1:0]   cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;

  // Payload registers
  logic [SAMPLE_BITS-1:0]  smp_q, smp_d;
  logic                    full_q, full_d;
  logic [LEN_BITS-1:0]     rem_q, rem_d;
  logic [SUM_BITS-1:0]     quo_q, quo_d;
  logic [DIV_CNT_BITS-1:0] step_q, step_d;
  logic                    out_det_q, out_det_d;
  logic [COUNT_BITS-1:0]   out_cnt_q, out_cnt_d;
  logic [SAMPLE_BITS-1:0]  out_mean_q, out_mean_d;
  logic                    out_full_q, out_full_d;

  logic                    in_xfer;
  logic                    out_free;
  logic [SAMPLE_BITS-1:0]  ring_rdata;

  // Effective averaging length: zero acts as one, clamp to the ring depth
  logic [CLAMP_BITS-1:0]   len_wide;
  logic [LEN_BITS-1:0]     n_eff;

  assign len_wide = CLAMP_BITS'(len_q);

  always_comb begin
    if (len_q == '0) begin
      n_eff = LEN_BITS'(1);
    end else if (len_wide > CLAMP_BITS'(MAX_WINDOW)) begin
      n_eff = LEN_BITS'(MAX_WINDOW);
    end else begin
      n_eff = LEN_BITS'(len_wide);
    end
  end

  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_xfer        = sample_i.valid & sample_i.ready;
  assign out_free       = !out_valid_q || result_o.ready;

  // Sample ring: read the oldest slot on the transfer, overwrite it in the next cycle in averaged mode
  awpd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_READ),
    .waddr_i (pos_q),
    .wdata_i (smp_q),
    .re_i    (in_xfer),
    .raddr_i (pos_q),
    .rdata_o (ring_rdata)
  );

  // Window update: drop the oldest sample once the window is full, add the new one
  logic                old_full;
  logic                new_full;
  logic [SUM_BITS-1:0] sum_after;
  logic [LEN_BITS-1:0] fill_after;
  logic [LEN_BITS-1:0] pos_inc;
  logic [POS_BITS-1:0] pos_after;

  assign old_full   = (fill_q >= n_eff);
  assign sum_after  = sum_q - (old_full ? SUM_BITS'(ring_rdata) : '0) + SUM_BITS'(smp_q);
  assign fill_after = old_full ? fill_q : fill_q + LEN_BITS'(1);
  assign new_full   = (fill_after >= n_eff);
  assign pos_inc    = LEN_BITS'(pos_q) + LEN_BITS'(1);
  assign pos_after  = (pos_inc >= n_eff) ? '0 : pos_inc[POS_BITS-1:0];

  // Divider step: shift one dividend bit into the remainder, subtract when it fits
  logic [LEN_BITS-1:0] trial;
  logic                trial_fits;

  assign trial      = {rem_q[POS_BITS-1:0], quo_q[SUM_BITS-1]};
  assign trial_fits = (trial >= n_eff);

  // Window test: symmetric around the threshold when averaging, one-sided in raw mode
  logic                         do_eval;
  logic [SAMPLE_BITS-1:0]       mean_eval;
  logic signed [CMP_BITS-1:0]   val_s, thr_s, wid_s, lo_s, hi_s;
  logic                         hit;
  logic [COUNT_BITS-1:0]        cnt_next;
  logic                         det;

  assign do_eval   = !mode_q || full_q;
  assign mean_eval = !mode_q ? smp_q : (full_q ? quo_q[SAMPLE_BITS-1:0] : '0);
  assign val_s     = signed'(CMP_BITS'(mean_eval));
  assign thr_s     = signed'(CMP_BITS'(thr_q));
  assign wid_s     = signed'(CMP_BITS'(wid_q));
  assign lo_s      = thr_s - (mode_q ? wid_s : '0);
  assign hi_s      = thr_s + wid_s;
  assign hit       = (val_s >= lo_s) && (val_s <= hi_s);
  assign cnt_next  = !hit ? '0 : ((cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_BITS'(1));
  assign det       = (HCMP_BITS'(cnt_next) >= HCMP_BITS'(hold_q));

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    smp_d       = smp_q;
    full_d      = full_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    out_det_d   = out_det_q;
    out_cnt_d   = out_cnt_q;
    out_mean_d  = out_mean_q;
    out_full_d  = out_full_q;
    thr_d       = thr_q;
    wid_d       = wid_q;
    hold_d      = hold_q;
    len_d       = len_q;
    mode_d      = mode_q;

    // Drop the held result once the consumer takes it
    out_valid_d = out_valid_q && !result_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          smp_d   = sample_i.light_sample;
          full_d  = 1'b0;
          state_d = mode_q ? ST_READ : ST_EVAL;
        end
      end
      ST_READ: begin
        sum_d   = sum_after;
        fill_d  = fill_after;
        pos_d   = pos_after;
        full_d  = new_full;
        rem_d   = '0;
        quo_d   = sum_after;
        step_d  = DIV_CNT_BITS'(SUM_BITS - 1);
        state_d = new_full ? ST_DIV : ST_EVAL;
      end
      ST_DIV: begin
        rem_d = trial_fits ? trial - n_eff : trial;
        quo_d = {quo_q[SUM_BITS-2:0], trial_fits};
        if (step_q == '0) begin
          state_d = ST_EVAL;
        end else begin
          step_d = step_q - DIV_CNT_BITS'(1);
        end
      end
      ST_EVAL: begin
        // Hold here until the output register frees up, so the counter moves once
        if (out_free) begin
          if (do_eval) begin
            cnt_d = cnt_next;
          end
          out_det_d   = do_eval && det;
          out_cnt_d   = do_eval ? cnt_next : cnt_q;
          out_mean_d  = mean_eval;
          out_full_d  = full_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Writes must come only while idle (the block does not enforce it); any known register clears the window
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD:    thr_d  = cfg_data_i[THR_BITS-1:0];
        CFG_WINDOW_WIDTH: wid_d  = cfg_data_i[WID_BITS-1:0];
        CFG_HOLD:         hold_d = cfg_data_i[HOLD_BITS-1:0];
        CFG_AVG_LENGTH:   len_d  = cfg_data_i[LEN_CFG_BITS-1:0];
        CFG_AVG_MODE:     mode_d = cfg_data_i[0];
        default: ;
      endcase
      if (cfg_idx_i == CFG_THRESHOLD || cfg_idx_i == CFG_WINDOW_WIDTH ||
          cfg_idx_i == CFG_HOLD || cfg_idx_i == CFG_AVG_LENGTH ||
          cfg_idx_i == CFG_AVG_MODE) begin
        pos_d  = '0;
        fill_d = '0;
        sum_d  = '0;
        cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= '0;
      wid_q       <= '0;
      hold_q      <= '0;
      len_q       <= LEN_RESET;
      mode_q      <= MODE_RESET;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      thr_q       <= thr_d;
      wid_q       <= wid_d;
      hold_q      <= hold_d;
      len_q       <= len_d;
      mode_q      <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q      <= smp_d;
    full_q     <= full_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    step_q     <= step_d;
    out_det_q  <= out_det_d;
    out_cnt_q  <= out_cnt_d;
    out_mean_q <= out_mean_d;
    out_full_q <= out_full_d;
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.detected    = out_det_q;
  assign result_o.run_count   = out_cnt_q;
  assign result_o.mean_value  = out_mean_q;
  assign result_o.window_full = out_full_q;

  // Fill level never runs past the effective length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= n_eff)
    else $error("fill level exceeds averaging length");

  // Ring pointer stays inside the active window
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_BITS'(pos_q) < n_eff)
    else $error("ring position outside window");

  // An empty window carries no sum
  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (sum_q == '0))
    else $error("window sum nonzero with empty window");

  // A finished quotient always fits the sample width
  a_mean_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && full_q && $past(state_q) == ST_DIV)
      |-> ((quo_q >> SAMPLE_BITS) == '0))
    else $error("mean overflows sample width");

endmodule

`default_nettype wire

// ===== rtl/awpd_ram.sv =====
`default_nettype none

module awpd_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 16,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== test/awpd_detect_checker.sv =====
module awpd_detect_checker import awpd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  awpd_in_if                       sample_mon,
  awpd_out_if                      result_mon,
  output int unsigned              fault_count_o,
  output int unsigned              backlog_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int CB = COUNT_BITS_DEF;
  localparam int MW = MAX_WINDOW_DEF;
  localparam int SUM_BITS = SB + $clog2(MW);

  typedef struct packed {
    logic          detected;
    logic [CB-1:0] run_count;
    logic [SB-1:0] mean_value;
    logic          window_full;
  } reading_t;

  // Register shadow
  logic [THR_BITS-1:0]     thr;
  logic [WID_BITS-1:0]     wid;
  logic [HOLD_BITS-1:0]    hold;
  logic [LEN_CFG_BITS-1:0] avg_len;
  logic                    avg_mode;

  // Window and run counter
  logic [SB-1:0]       ring [MW];
  int unsigned         ring_pos;
  int unsigned         fill;
  logic [SUM_BITS-1:0] win_sum;
  logic [CB-1:0]       run;

  reading_t    pending_readings [$];
  int unsigned faults;
  int unsigned results_seen;

  function automatic int unsigned span_len();
    if (avg_len == '0) return 1;
    if (avg_len > MW) return MW;
    return avg_len;
  endfunction

  function automatic void clear_window();
    ring_pos = 0;
    fill     = 0;
    win_sum  = '0;
    run      = '0;
  endfunction

  function automatic void tally(input logic hit);
    if (!hit) run = '0;
    else if (run != '1) run = run + 1'b1;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
    logic known;
    known = 1'b1;
    case (cfg_idx_e'(idx))
      CFG_THRESHOLD:    thr      = data[THR_BITS-1:0];
      CFG_WINDOW_WIDTH: wid      = data[WID_BITS-1:0];
      CFG_HOLD:         hold     = data[HOLD_BITS-1:0];
      CFG_AVG_LENGTH:   avg_len  = data[LEN_CFG_BITS-1:0];
      CFG_AVG_MODE:     avg_mode = data[0];
      default:          known    = 1'b0;
    endcase
    // unmapped index: no effect, window kept
    if (known) clear_window();
  endfunction

  function automatic reading_t predict_reading(input logic [SB-1:0] s);
    reading_t    r;
    int unsigned n;
    int unsigned pos;
    int          lo;
    int          hi;
    int          v;
    r = '0;
    if (avg_mode) begin
      n   = span_len();
      pos = ring_pos % MW;
      if (fill >= n) win_sum = win_sum - ring[pos];
      else fill++;
      ring[pos] = s;
      win_sum   = win_sum + s;
      pos++;
      ring_pos = (pos >= n) ? 0 : pos;
      if (fill >= n) begin
        r.window_full = 1'b1;
        r.mean_value  = SB'(win_sum / n);
        v  = int'(r.mean_value);
        lo = int'(thr) - int'(wid);
        hi = int'(thr) + int'(wid);
        tally(v >= lo && v <= hi);
        r.detected = (run >= hold);
      end
    end else begin
      r.mean_value = s;
      v  = int'(s);
      lo = int'(thr);
      hi = int'(thr) + int'(wid);
      tally(v >= lo && v <= hi);
      r.detected = (run >= hold);
    end
    r.run_count = run;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t got;
    reading_t want;
    reading_t fresh;
    if (!rst_ni) begin
      thr      = '0;
      wid      = '0;
      hold     = '0;
      avg_len  = LEN_RESET;
      avg_mode = MODE_RESET;
      clear_window();
      pending_readings.delete();
      faults        = 0;
      results_seen  = 0;
      fault_count_o <= 0;
      backlog_o     <= 0;
    end else begin
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_data_i);
      if (sample_mon.valid && sample_mon.ready) begin
        fresh = predict_reading(sample_mon.light_sample);
        pending_readings.insert(pending_readings.size(), fresh);
      end
      if (result_mon.valid && result_mon.ready) begin
        got.detected    = result_mon.detected;
        got.run_count   = result_mon.run_count;
        got.mean_value  = result_mon.mean_value;
        got.window_full = result_mon.window_full;
        if (pending_readings.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("%0t: result %0d arrived with nothing expected: ", $time, results_seen,
                     "det=%0b cnt=%0d mean=%0d full=%0b",
                     got.detected, got.run_count, got.mean_value, got.window_full);
        end else begin
          want = pending_readings.pop_front();
          if (got.detected !== want.detected || got.run_count !== want.run_count ||
              got.mean_value !== want.mean_value || got.window_full !== want.window_full) begin
            faults++;
            if (faults <= 10)
              $display("%0t: result %0d mismatch: ", $time, results_seen,
                       "expected det=%0b cnt=%0d mean=%0d full=%0b, ",
                       want.detected, want.run_count, want.mean_value, want.window_full,
                       "got det=%0b cnt=%0d mean=%0d full=%0b",
                       got.detected, got.run_count, got.mean_value, got.window_full);
          end
        end
        results_seen++;
      end
      fault_count_o <= faults;
      backlog_o     <= pending_readings.size();
    end
  end

endmodule

// ===== test/tb_averaged_window_persistence_detector.sv =====
module tb_averaged_window_persistence_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import awpd_pkg::*;

  // Index with no register behind it; a write there must leave the window alone
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = CFG_IDX_BITS'(7);
  // Cycles without any transfer before the run is declared hung
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 780;
  // All-hit samples at the largest hold; the run grows but stays short of it
  localparam int unsigned TAIL_ITEMS = 40;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  awpd_in_if  sample_if ();
  awpd_out_if result_if ();

  int unsigned fault_count;
  int unsigned backlog;

  // Idle odds in percent for each side, changed as the run goes through its phases
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned items_sent;

  // Shadow of the thresholds, used to aim samples at the accepted window
  int cur_thr;
  int cur_wid;

  averaged_window_persistence_detector dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  awpd_detect_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample_mon    (sample_if),
    .result_mon    (result_if),
    .fault_count_o (fault_count),
    .backlog_o     (backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side at random, one fresh draw per cycle
  always @(posedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: count cycles in which neither channel completes a transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (sample_if.valid && sample_if.ready) ||
          (result_if.valid && result_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_averaged_window_persistence_detector: done, errors");
    $finish;
  end

  // Drive one register write; the write lands on the next rising edge.
  // Leave the enable high so back-to-back writes need no extra edge.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (cfg_idx_e'(idx))
      CFG_THRESHOLD:    cur_thr = int'(data[THR_BITS-1:0]);
      CFG_WINDOW_WIDTH: cur_wid = int'(data[WID_BITS-1:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic close_writes();
    cfg_we_i <= 1'b0;
  endtask

  // Offer one sample and hold it until the transfer. Valid stays high on return,
  // so the next call either keeps it up or drops it for an idle gap first.
  task automatic push_sample(input logic [SAMPLE_BITS_DEF-1:0] s);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    sample_if.valid        <= 1'b1;
    sample_if.light_sample <= s;
    do @(posedge clk_i); while (!sample_if.ready);
    items_sent++;
  endtask

  // Drop valid and hold off until every expected result has been taken.
  // The first edge lets the checker account for the last sample transfer.
  task automatic settle();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
  endtask

  // Mostly aim near the window so runs build up, sometimes anywhere
  function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
    int spread;
    int val;
    if ($urandom_range(99) < 75) begin
      spread = cur_wid + 3;
      val = cur_thr + int'($urandom_range(2 * spread)) - spread;
      if (val < 0) val = 0;
      if (val > 255) val = 255;
      return SAMPLE_BITS_DEF'(val);
    end
    return SAMPLE_BITS_DEF'($urandom_range(255));
  endfunction

  // Rewrite a random subset of registers, at least one
  task automatic shuffle_config();
    logic wrote;
    int   pick;
    settle();
    wrote = 1'b0;
    while (!wrote) begin
      if ($urandom_range(1)) begin
        write_reg(CFG_THRESHOLD, CFG_DATA_BITS'($urandom_range(255)));
        wrote = 1'b1;
      end
      if ($urandom_range(1)) begin
        if ($urandom_range(99) < 60)
          write_reg(CFG_WINDOW_WIDTH, CFG_DATA_BITS'($urandom_range(12)));
        else
          write_reg(CFG_WINDOW_WIDTH, CFG_DATA_BITS'($urandom_range(255)));
        wrote = 1'b1;
      end
      if ($urandom_range(1)) begin
        pick = $urandom_range(99);
        if (pick < 40)      write_reg(CFG_HOLD, CFG_DATA_BITS'($urandom_range(3)));
        else if (pick < 80) write_reg(CFG_HOLD, CFG_DATA_BITS'($urandom_range(12, 4)));
        else if (pick < 90) write_reg(CFG_HOLD, '1);
        else                write_reg(CFG_HOLD, CFG_DATA_BITS'($urandom_range(65535)));
        wrote = 1'b1;
      end
      if ($urandom_range(1)) begin
        pick = $urandom_range(99);
        // lengths of zero and above the ring size get clamped by the block
        if (pick < 70)      write_reg(CFG_AVG_LENGTH, CFG_DATA_BITS'($urandom_range(5, 1)));
        else if (pick < 90) write_reg(CFG_AVG_LENGTH, CFG_DATA_BITS'($urandom_range(16, 6)));
        else                write_reg(CFG_AVG_LENGTH, CFG_DATA_BITS'($urandom_range(31)));
        wrote = 1'b1;
      end
      if ($urandom_range(1)) begin
        write_reg(CFG_AVG_MODE, CFG_DATA_BITS'($urandom_range(1)));
        wrote = 1'b1;
      end
    end
    close_writes();
  endtask

  initial begin
    int unsigned seg_len;
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = '0;
    cfg_data_i             = '0;
    sample_if.valid        = 1'b0;
    sample_if.light_sample = '0;
    send_idle_pct          = 27;
    recv_idle_pct          = 56;
    items_sent             = 0;
    cur_thr                = 0;
    cur_wid                = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: length one, zero hold, so even a miss reports detection
    push_sample(8'd0);
    push_sample(8'd255);
    push_sample(8'd0);

    // Raw mode with the window at the top edge; mode bit taken from bit 0 only
    settle();
    write_reg(CFG_AVG_MODE, 16'hFFFE);
    write_reg(CFG_THRESHOLD, 16'd255);
    write_reg(CFG_WINDOW_WIDTH, 16'd255);
    write_reg(CFG_HOLD, 16'd2);
    close_writes();
    push_sample(8'd254);
    push_sample(8'd255);
    push_sample(8'd255);
    // An unmapped write must not clear the run in progress
    settle();
    write_reg(CFG_UNMAPPED, '1);
    close_writes();
    push_sample(8'd255);

    // Averaged mode, length zero acting as one, miss still detected at zero hold
    settle();
    write_reg(CFG_AVG_MODE, 16'd1);
    write_reg(CFG_AVG_LENGTH, 16'd0);
    write_reg(CFG_THRESHOLD, 16'd0);
    write_reg(CFG_WINDOW_WIDTH, 16'd5);
    write_reg(CFG_HOLD, 16'd0);
    close_writes();
    push_sample(8'd5);
    push_sample(8'd6);

    // Oversized length clamps to the full ring; fill it with the largest sample
    settle();
    write_reg(CFG_AVG_LENGTH, 16'd31);
    write_reg(CFG_THRESHOLD, 16'd250);
    write_reg(CFG_HOLD, 16'd1);
    close_writes();
    repeat (16) push_sample(8'd255);

    // Random segments; each starts after a full drain and a fresh setting
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 27;
        recv_idle_pct = 56;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 56;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      shuffle_config();
      seg_len = $urandom_range(45, 10);
      repeat (seg_len) push_sample(pick_sample());
    end

    // Every raw sample hits; the run climbs with no detection at the largest hold
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_AVG_MODE, 16'd0);
    write_reg(CFG_THRESHOLD, 16'd0);
    write_reg(CFG_WINDOW_WIDTH, 16'd255);
    write_reg(CFG_HOLD, 16'hFFFF);
    close_writes();
    repeat (TAIL_ITEMS) push_sample(SAMPLE_BITS_DEF'($urandom_range(255)));

    settle();
    repeat (20) @(posedge clk_i);
    if (fault_count == 0 && backlog == 0) begin
      $display("tb_averaged_window_persistence_detector: done, clean");
    end else begin
      $display("tb_averaged_window_persistence_detector: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/awpd_pkg.sv
rtl/awpd_if.sv
rtl/awpd_ram.sv
rtl/averaged_window_persistence_detector.sv
test/awpd_detect_checker.sv
test/tb_averaged_window_persistence_detector.sv
